/* rtl/tgarow_pkg.sv */
package tgarow_pkg;

  localparam int HeaderBytes = 18;

  // Parser phases
  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_SKIP   = 2'd1;
  localparam logic [1:0] PH_PIXELS = 2'd2;
  localparam logic [1:0] PH_DONE   = 2'd3;

  // Result status codes
  localparam logic [2:0] ST_PIXEL  = 3'd0;
  localparam logic [2:0] ST_CMAP   = 3'd1;
  localparam logic [2:0] ST_TYPE   = 3'd2;
  localparam logic [2:0] ST_DEPTH  = 3'd3;
  localparam logic [2:0] ST_HEIGHT = 3'd4;
  localparam logic [2:0] ST_TRUNC  = 3'd5;

  localparam logic [7:0] TrueColorType = 8'd2;
  localparam logic [7:0] TrueColorBpp  = 8'd24;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       file_start;
    logic       file_end;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [15:0] pixel_index;
    logic [15:0] image_width;
    logic        last_pixel;
  } result_t;

endpackage

/* rtl/tgarow_engine.sv */
module tgarow_engine (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  tgarow_pkg::in_item_t item,
  output logic                has_result,
  output tgarow_pkg::result_t result
);
  import tgarow_pkg::*;

  logic [1:0]  phase, phase_next, phase_cur;
  logic [4:0]  hpos, hpos_next, hpos_cur;
  logic [7:0]  id_len, id_len_next, id_len_cur;
  logic [7:0]  cmap_type, cmap_type_next, cmap_type_cur;
  logic [7:0]  img_type, img_type_next, img_type_cur;
  logic [15:0] cmap_len, cmap_len_next, cmap_len_cur;
  logic [7:0]  cmap_depth, cmap_depth_next, cmap_depth_cur;
  logic [15:0] width, width_next, width_cur;
  logic [15:0] height, height_next, height_cur;
  logic [7:0]  depth, depth_next, depth_cur;
  logic [21:0] skip, skip_next, skip_cur;
  logic [1:0]  byte_phase, byte_phase_next, byte_phase_cur;
  logic [7:0]  held_blue, held_blue_next, held_blue_cur;
  logic [7:0]  held_green, held_green_next, held_green_cur;
  logic [15:0] done_cnt, done_cnt_next, done_cnt_cur;

  logic [4:0]  hpos_inc;
  logic [20:0] cmap_bytes;
  logic [21:0] skip_total;
  logic [21:0] skip_dec;
  logic [16:0] idx_inc;
  logic        is_last;
  logic        emitted;

  // A start byte sees the reset state
  always_comb begin
    if (item.file_start) begin
      phase_cur      = PH_HEADER;
      hpos_cur       = '0;
      id_len_cur     = '0;
      cmap_type_cur  = '0;
      img_type_cur   = '0;
      cmap_len_cur   = '0;
      cmap_depth_cur = '0;
      width_cur      = '0;
      height_cur     = '0;
      depth_cur      = '0;
      skip_cur       = '0;
      byte_phase_cur = '0;
      held_blue_cur  = '0;
      held_green_cur = '0;
      done_cnt_cur   = '0;
    end else begin
      phase_cur      = phase;
      hpos_cur       = hpos;
      id_len_cur     = id_len;
      cmap_type_cur  = cmap_type;
      img_type_cur   = img_type;
      cmap_len_cur   = cmap_len;
      cmap_depth_cur = cmap_depth;
      width_cur      = width;
      height_cur     = height;
      depth_cur      = depth;
      skip_cur       = skip;
      byte_phase_cur = byte_phase;
      held_blue_cur  = held_blue;
      held_green_cur = held_green;
      done_cnt_cur   = done_cnt;
    end
  end

  always_comb begin
    phase_next      = phase_cur;
    hpos_next       = hpos_cur;
    id_len_next     = id_len_cur;
    cmap_type_next  = cmap_type_cur;
    img_type_next   = img_type_cur;
    cmap_len_next   = cmap_len_cur;
    cmap_depth_next = cmap_depth_cur;
    width_next      = width_cur;
    height_next     = height_cur;
    depth_next      = depth_cur;
    skip_next       = skip_cur;
    byte_phase_next = byte_phase_cur;
    held_blue_next  = held_blue_cur;
    held_green_next = held_green_cur;
    done_cnt_next   = done_cnt_cur;
    emitted         = 1'b0;
    result          = '0;

    hpos_inc   = hpos_cur + 5'd1;
    cmap_bytes = 21'({5'd0, cmap_len_next} * {16'd0, cmap_depth_next[7:3]});
    skip_total = {14'd0, id_len_next} + {1'b0, cmap_bytes};
    skip_dec   = skip_cur - 22'd1;
    idx_inc    = {1'b0, done_cnt_cur} + 17'd1;
    is_last    = idx_inc >= {1'b0, width_cur};

    case (phase_cur)
      PH_HEADER: begin
        case (hpos_cur)
          5'd0:  id_len_next = item.data_byte;
          5'd1:  cmap_type_next = item.data_byte;
          5'd2:  img_type_next = item.data_byte;
          5'd5:  cmap_len_next = {8'd0, item.data_byte};
          5'd6:  cmap_len_next = {item.data_byte, cmap_len_cur[7:0]};
          5'd7:  cmap_depth_next = item.data_byte;
          5'd12: width_next = {8'd0, item.data_byte};
          5'd13: width_next = {item.data_byte, width_cur[7:0]};
          5'd14: height_next = {8'd0, item.data_byte};
          5'd15: height_next = {item.data_byte, height_cur[7:0]};
          5'd16: depth_next = item.data_byte;
          default: ;
        endcase
        hpos_next = hpos_inc;
        if (hpos_inc >= 5'(HeaderBytes)) begin
          // Format checks, in priority order
          if (cmap_type_next != 8'd0) begin
            emitted = 1'b1;
            result.status = ST_CMAP;
          end else if (img_type_next != TrueColorType) begin
            emitted = 1'b1;
            result.status = ST_TYPE;
          end else if (depth_next != TrueColorBpp) begin
            emitted = 1'b1;
            result.status = ST_DEPTH;
          end else if (height_next != 16'd1) begin
            emitted = 1'b1;
            result.status = ST_HEIGHT;
          end else begin
            skip_next = skip_total;
            if (skip_total != '0) phase_next = PH_SKIP;
            else if (width_next == '0) phase_next = PH_DONE;
            else phase_next = PH_PIXELS;
          end
        end
      end
      PH_SKIP: begin
        skip_next = skip_dec;
        if (skip_dec == '0) begin
          phase_next = (width_cur == '0) ? PH_DONE : PH_PIXELS;
        end
      end
      PH_PIXELS: begin
        if (byte_phase_cur == 2'd0) begin
          held_blue_next  = item.data_byte;
          byte_phase_next = 2'd1;
        end else if (byte_phase_cur == 2'd1) begin
          held_green_next = item.data_byte;
          byte_phase_next = 2'd2;
        end else begin
          byte_phase_next = 2'd0;
          emitted = 1'b1;
          if (item.file_end && !is_last) begin
            result.status = ST_TRUNC;
          end else begin
            result.status      = ST_PIXEL;
            result.red         = item.data_byte;
            result.green       = held_green_cur;
            result.blue        = held_blue_cur;
            result.pixel_index = done_cnt_cur;
            result.last_pixel  = is_last;
            result.image_width = width_cur;
            done_cnt_next      = idx_inc[15:0];
            if (is_last) phase_next = PH_DONE;
          end
        end
      end
      default: ;
    endcase

    // Early end of file
    if (!emitted && item.file_end && phase_cur != PH_DONE && phase_next != PH_DONE) begin
      emitted = 1'b1;
      result.status = ST_TRUNC;
    end

    // Common error fields
    if (emitted && result.status != ST_PIXEL) begin
      result.pixel_index = done_cnt_cur;
      result.image_width = width_next;
      result.last_pixel  = 1'b1;
      phase_next         = PH_DONE;
    end

    has_result = emitted && phase_cur != PH_DONE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HEADER;
      hpos       <= '0;
      id_len     <= '0;
      cmap_type  <= '0;
      img_type   <= '0;
      cmap_len   <= '0;
      cmap_depth <= '0;
      width      <= '0;
      height     <= '0;
      depth      <= '0;
      skip       <= '0;
      byte_phase <= '0;
      held_blue  <= '0;
      held_green <= '0;
      done_cnt   <= '0;
    end else if (step) begin
      phase      <= phase_next;
      hpos       <= hpos_next;
      id_len     <= id_len_next;
      cmap_type  <= cmap_type_next;
      img_type   <= img_type_next;
      cmap_len   <= cmap_len_next;
      cmap_depth <= cmap_depth_next;
      width      <= width_next;
      height     <= height_next;
      depth      <= depth_next;
      skip       <= skip_next;
      byte_phase <= byte_phase_next;
      held_blue  <= held_blue_next;
      held_green <= held_green_next;
      done_cnt   <= done_cnt_next;
    end
  end

endmodule

/* rtl/tga_truecolor_row_parser.sv */
// Channel   Direction  Valid      Stall      Word
// input     in         in_valid   in_stall   in_data  (data_byte, file_start, file_end)
// result    out        out_valid  out_stall  out_data (status, rgb, index, width, last)
//
// One word per cycle sustained while the result side does not stall. An accepted
// byte is loaded into the input register; the parser state and the result register
// then update together when the parser steps, which a result-side stall can hold off.
// Reset (rst, synchronous) puts the parser in the header phase at byte 0.
// A stall on the result side holds the parser step, which then stalls the input.
module tga_truecolor_row_parser (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  tgarow_pkg::in_item_t in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output tgarow_pkg::result_t  out_data
);
  import tgarow_pkg::*;

  logic     in_full;
  in_item_t in_reg;
  logic     out_free;
  logic     step;
  logic     has_result;
  result_t  result;

  // Advance the parser only when the result slot is empty or draining
  assign out_free = !out_valid || !out_stall;
  assign step     = in_full && out_free;
  assign in_stall = in_full && !out_free;

  // Input register: load on accept, drop once consumed
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_full <= 1'b1;
    end else if (step) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_reg <= in_data;
    end
  end

  tgarow_engine u_engine (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .item       (in_reg),
    .has_result (has_result),
    .result     (result)
  );

  // Result register: hold under stall, load on each parser step
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= has_result;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && has_result) begin
      out_data <= result;
    end
  end

endmodule

/* tb/tga_row_checker.sv */
module tga_row_checker
  import tgarow_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  logic     in_stall,
  input  in_item_t in_data,
  input  logic     out_valid,
  input  logic     out_stall,
  input  result_t  out_data,
  output int       mismatches,
  output int       outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  // Parser state, tracked on accepted words
  logic [1:0]  phase;
  logic [4:0]  hdr_pos;
  logic [7:0]  id_len;
  logic [7:0]  cmap_kind;
  logic [7:0]  img_kind;
  logic [15:0] cmap_entries;
  logic [7:0]  cmap_bits;
  logic [15:0] row_width;
  logic [15:0] row_height;
  logic [7:0]  pix_bits;
  logic [21:0] skip_left;
  logic [1:0]  byte_slot;
  logic [7:0]  blue_hold;
  logic [7:0]  green_hold;
  logic [15:0] pix_count;

  result_t expected_px[$];
  result_t want;
  int      fail_count = 0;
  int      pending_n = 0;

  assign mismatches  = fail_count;
  assign outstanding = pending_n;

  function automatic void restart_parse();
    phase        = PH_HEADER;
    hdr_pos      = '0;
    id_len       = '0;
    cmap_kind    = '0;
    img_kind     = '0;
    cmap_entries = '0;
    cmap_bits    = '0;
    row_width    = '0;
    row_height   = '0;
    pix_bits     = '0;
    skip_left    = '0;
    byte_slot    = '0;
    blue_hold    = '0;
    green_hold   = '0;
    pix_count    = '0;
  endfunction

  // Append one expected word at the tail
  function automatic void enqueue_word(input result_t r);
    expected_px = {expected_px, r};
  endfunction

  function automatic void reject(input logic [2:0] code);
    result_t r;
    r             = '0;
    r.status      = code;
    r.pixel_index = pix_count;
    r.image_width = row_width;
    r.last_pixel  = 1'b1;
    enqueue_word(r);
    phase = PH_DONE;
  endfunction

  function automatic void parse_byte(input in_item_t w);
    logic [7:0]  d;
    logic        last_one;
    int unsigned span;
    result_t     r;
    d = w.data_byte;
    if (w.file_start) restart_parse();
    case (phase)
      PH_HEADER: begin
        case (hdr_pos)
          5'd0:  id_len = d;
          5'd1:  cmap_kind = d;
          5'd2:  img_kind = d;
          5'd5:  cmap_entries = {8'd0, d};
          5'd6:  cmap_entries[15:8] = d;
          5'd7:  cmap_bits = d;
          5'd12: row_width = {8'd0, d};
          5'd13: row_width[15:8] = d;
          5'd14: row_height = {8'd0, d};
          5'd15: row_height[15:8] = d;
          5'd16: pix_bits = d;
          default: ;
        endcase
        hdr_pos = hdr_pos + 5'd1;
        if (hdr_pos >= 5'(HeaderBytes)) begin
          if (cmap_kind != 8'd0) begin
            reject(ST_CMAP);
            return;
          end
          if (img_kind != TrueColorType) begin
            reject(ST_TYPE);
            return;
          end
          if (pix_bits != TrueColorBpp) begin
            reject(ST_DEPTH);
            return;
          end
          if (row_height != 16'd1) begin
            reject(ST_HEIGHT);
            return;
          end
          span      = 32'(id_len) + 32'(cmap_entries) * (32'(cmap_bits) / 32'd8);
          skip_left = span[21:0];
          if (skip_left != '0) phase = PH_SKIP;
          else if (row_width == '0) phase = PH_DONE;
          else phase = PH_PIXELS;
        end
      end
      PH_SKIP: begin
        skip_left = skip_left - 22'd1;
        if (skip_left == '0) phase = (row_width == '0) ? PH_DONE : PH_PIXELS;
      end
      PH_PIXELS: begin
        if (byte_slot == 2'd0) begin
          blue_hold = d;
          byte_slot = 2'd1;
        end else if (byte_slot == 2'd1) begin
          green_hold = d;
          byte_slot  = 2'd2;
        end else begin
          last_one  = ({16'd0, pix_count} + 32'd1) >= {16'd0, row_width};
          byte_slot = 2'd0;
          if (w.file_end && !last_one) begin
            reject(ST_TRUNC);
            return;
          end
          r.status      = ST_PIXEL;
          r.red         = d;
          r.green       = green_hold;
          r.blue        = blue_hold;
          r.pixel_index = pix_count;
          r.image_width = row_width;
          r.last_pixel  = last_one;
          enqueue_word(r);
          pix_count = pix_count + 16'd1;
          if (last_one) phase = PH_DONE;
          return;
        end
      end
      default: return;
    endcase
    if (w.file_end && phase != PH_DONE) reject(ST_TRUNC);
  endfunction

  function automatic void check_field(input string name, input logic [15:0] exp_v,
                                      input logic [15:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      restart_parse();
      expected_px.delete();
      pending_n <= 0;
    end else begin
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        if (expected_px.size() == 0) begin
          $display("%0t: unexpected result word, expected none, actual %h", $time, out_data);
          fail_count++;
        end else begin
          want = expected_px.pop_front();
          check_field("status", 16'(want.status), 16'(out_data.status));
          check_field("red", 16'(want.red), 16'(out_data.red));
          check_field("green", 16'(want.green), 16'(out_data.green));
          check_field("blue", 16'(want.blue), 16'(out_data.blue));
          check_field("pixel_index", want.pixel_index, out_data.pixel_index);
          check_field("image_width", want.image_width, out_data.image_width);
          check_field("last_pixel", 16'(want.last_pixel), 16'(out_data.last_pixel));
        end
      end
      if (in_valid === 1'b1 && in_stall === 1'b0) parse_byte(in_data);
      pending_n <= expected_px.size();
    end
  end

endmodule

/* tb/tga_truecolor_row_parser_tb.sv */
module tga_truecolor_row_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tgarow_pkg::*;

  // Generous bound for the watchdog on the length of a run.
  localparam int CycleLimit = 200000;
  // Cycle at which the receiver starts its long hold-off, and its length.
  localparam int HoldStart  = 1000;
  localparam int HoldCycles = 300;

  logic     clk;
  logic     rst;
  logic     in_valid;
  logic     in_stall;
  in_item_t in_data;
  logic     out_valid;
  logic     out_stall;
  result_t  out_data;

  int mismatches;
  int outstanding;
  int cycle_count = 0;
  int send_idle_pct = 20;
  int recv_idle_pct = 57;
  int bytes_sent = 0;

  // Bytes of the file under construction
  logic [7:0] tga_bytes[$];

  tga_truecolor_row_parser u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  tga_row_checker u_check (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: abort the run if it hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // Result receiver: random stall at the current rate, plus one long hold-off
  // so the parser pipeline fills and pushes back on the byte stream.
  initial begin
    int hold_left;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (cycle_count == HoldStart) hold_left = HoldCycles;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Append one byte to the file under construction.
  function automatic void add_byte(input logic [7:0] b);
    tga_bytes = {tga_bytes, b};
  endfunction

  // Offer one word; idle first at the sender rate, then hold it until taken.
  task automatic push_word(input logic [7:0] b, input logic s, input logic e);
    in_item_t w;
    w.data_byte  = b;
    w.file_start = s;
    w.file_end   = e;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Assemble a file: 18-byte header, skip bytes, then npix BGR triples.
  // Fields the parser ignores get random bytes.
  task automatic build_tga(input logic [7:0] id_n, input logic [7:0] cmap_kind,
                           input logic [7:0] img_kind, input logic [15:0] cmap_n,
                           input logic [7:0] cmap_bits, input logic [15:0] wid,
                           input logic [15:0] hgt, input logic [7:0] bpp,
                           input int npix);
    int skip_n;
    tga_bytes.delete();
    for (int i = 0; i < HeaderBytes; i++) add_byte(8'($urandom_range(255)));
    tga_bytes[0]  = id_n;
    tga_bytes[1]  = cmap_kind;
    tga_bytes[2]  = img_kind;
    tga_bytes[5]  = cmap_n[7:0];
    tga_bytes[6]  = cmap_n[15:8];
    tga_bytes[7]  = cmap_bits;
    tga_bytes[12] = wid[7:0];
    tga_bytes[13] = wid[15:8];
    tga_bytes[14] = hgt[7:0];
    tga_bytes[15] = hgt[15:8];
    tga_bytes[16] = bpp;
    skip_n = int'(id_n) + int'(cmap_n) * (int'(cmap_bits) / 8);
    repeat (skip_n + 3 * npix) add_byte(8'($urandom_range(255)));
  endtask

  // Send the first n bytes; mark the start and the end word as asked.
  task automatic send_tga(input int n, input logic with_start, input logic with_end);
    for (int i = 0; i < n; i++)
      push_word(tga_bytes[i], with_start && i == 0, with_end && i == n - 1);
    bytes_sent += n;
  endtask

  // Trailing garbage after a finished file; the parser must drop all of it.
  task automatic send_noise(input int n);
    repeat (n) push_word(8'($urandom_range(255)), 1'b0, 1'($urandom_range(1)));
  endtask

  // One random file. Mostly well-formed rows with random content; the rest
  // are bad headers, truncated files and files abandoned by a restart.
  task automatic random_tga();
    logic [7:0]  id_n, cmap_kind, img_kind, cmap_bits, bpp;
    logic [15:0] cmap_n, wid, hgt;
    int          npix, len, pick;
    id_n      = 8'($urandom_range(3));
    cmap_kind = 8'd0;
    img_kind  = TrueColorType;
    bpp       = TrueColorBpp;
    hgt       = 16'd1;
    // Depth below 8 makes the color map take no bytes, so any length is safe.
    if ($urandom_range(1)) begin
      cmap_n    = 16'($urandom_range(16'hFFFF));
      cmap_bits = 8'($urandom_range(7));
    end else begin
      cmap_n = 16'($urandom_range(4));
      case ($urandom_range(4))
        0: cmap_bits = 8'd8;
        1: cmap_bits = 8'd15;
        2: cmap_bits = 8'd16;
        3: cmap_bits = 8'd24;
        default: cmap_bits = 8'd32;
      endcase
    end
    wid = 16'($urandom_range(1, 10));
    if ($urandom_range(19) == 0) wid = 16'd0;
    npix = int'(wid);
    // Wide row: exercise the high width bits, cut short after a few pixels.
    if ($urandom_range(19) == 0) begin
      wid  = 16'($urandom_range(16'hFFFF));
      npix = 4;
    end
    pick = $urandom_range(99);
    if (pick < 15) begin
      case ($urandom_range(4))
        0: cmap_kind = 8'($urandom_range(1, 255));
        1: begin
          img_kind = 8'($urandom_range(255));
          if (img_kind == TrueColorType) img_kind = 8'd3;
        end
        2: begin
          bpp = 8'($urandom_range(255));
          if (bpp == TrueColorBpp) bpp = 8'd32;
        end
        3: begin
          hgt = 16'($urandom_range(16'hFFFF));
          if (hgt == 16'd1) hgt = 16'd0;
        end
        default: begin
          cmap_kind = 8'($urandom_range(255));
          img_kind  = 8'($urandom_range(255));
          bpp       = 8'($urandom_range(255));
          hgt       = 16'($urandom_range(16'hFFFF));
        end
      endcase
    end
    build_tga(id_n, cmap_kind, img_kind, cmap_n, cmap_bits, wid, hgt, bpp, npix);
    len = tga_bytes.size();
    if (pick < 15) begin
      // Header only; the end may land on the very byte that rejects it.
      send_tga(HeaderBytes, 1'b1, 1'($urandom_range(1)));
    end else if (pick < 30) begin
      send_tga($urandom_range(1, len), 1'b1, 1'b1);
    end else if (pick < 40) begin
      send_tga($urandom_range(1, len), 1'b1, 1'b0);
    end else begin
      send_tga(len, 1'b1, 1'b1);
      if ($urandom_range(6) == 0) send_noise($urandom_range(1, 4));
    end
  endtask

  initial begin
    int target;
    rst      = 1'b1;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Parser is in the header phase out of reset: no start mark needed.
    // Two pixels at the color extremes.
    build_tga(8'd0, 8'd0, TrueColorType, 16'd0, 8'd0, 16'd2, 16'd1, TrueColorBpp, 2);
    for (int i = 18; i < 21; i++) tga_bytes[i] = 8'h00;
    for (int i = 21; i < 24; i++) tga_bytes[i] = 8'hFF;
    send_tga(24, 1'b0, 1'b1);

    // ID field plus a 24-bit color map to skip; then drop trailing bytes.
    build_tga(8'd3, 8'd0, TrueColorType, 16'd2, 8'd24, 16'd1, 16'd1, TrueColorBpp, 1);
    send_tga(tga_bytes.size(), 1'b1, 1'b1);
    send_noise(3);

    // Each format error; all but the second end on the rejecting byte itself.
    build_tga(8'd0, 8'd1, TrueColorType, 16'd0, 8'd0, 16'd1, 16'd1, TrueColorBpp, 0);
    send_tga(HeaderBytes, 1'b1, 1'b1);
    build_tga(8'd0, 8'd0, 8'd3, 16'd0, 8'd0, 16'd1, 16'd1, TrueColorBpp, 0);
    send_tga(HeaderBytes, 1'b1, 1'b0);
    build_tga(8'd0, 8'd0, TrueColorType, 16'd0, 8'd0, 16'd1, 16'd1, 8'd32, 0);
    send_tga(HeaderBytes, 1'b1, 1'b1);
    build_tga(8'd0, 8'd0, TrueColorType, 16'd0, 8'd0, 16'd1, 16'h0100, TrueColorBpp, 0);
    send_tga(HeaderBytes, 1'b1, 1'b1);

    // Zero width with a skip: no results, later bytes dropped.
    build_tga(8'd2, 8'd0, TrueColorType, 16'd0, 8'd0, 16'd0, 16'd1, TrueColorBpp, 0);
    send_tga(20, 1'b1, 1'b0);
    send_noise(2);
    // Zero width, no skip, end on the last header byte: still no result.
    build_tga(8'd0, 8'd0, TrueColorType, 16'd0, 8'd0, 16'd0, 16'd1, TrueColorBpp, 0);
    send_tga(HeaderBytes, 1'b1, 1'b1);

    // Truncation inside the header (only the low width byte captured).
    build_tga(8'd0, 8'd0, TrueColorType, 16'd0, 8'd0, 16'h0203, 16'd1, TrueColorBpp, 3);
    send_tga(13, 1'b1, 1'b1);
    // Truncation inside the skip.
    build_tga(8'd4, 8'd0, TrueColorType, 16'd0, 8'd0, 16'd3, 16'd1, TrueColorBpp, 3);
    send_tga(20, 1'b1, 1'b1);
    // End on the byte that finishes a non-final pixel, then mid-pixel.
    build_tga(8'd0, 8'd0, TrueColorType, 16'd0, 8'd0, 16'd3, 16'd1, TrueColorBpp, 3);
    send_tga(24, 1'b1, 1'b1);
    send_tga(22, 1'b1, 1'b1);

    // Restart in the middle of a row.
    build_tga(8'd0, 8'd0, TrueColorType, 16'd0, 8'd0, 16'd4, 16'd1, TrueColorBpp, 4);
    send_tga(25, 1'b1, 1'b0);
    // Widest row and a large ignored color map, cut after two pixels.
    build_tga(8'd0, 8'd0, TrueColorType, 16'hFFFF, 8'd7, 16'hFFFF, 16'd1,
              TrueColorBpp, 2);
    send_tga(24, 1'b1, 1'b1);
    // Extra pixel bytes after the final pixel are dropped.
    build_tga(8'd0, 8'd0, TrueColorType, 16'd0, 8'd0, 16'd1, 16'd1, TrueColorBpp, 3);
    send_tga(27, 1'b1, 1'b1);

    // Random files in three idle regimes: sender light / receiver heavy,
    // the reverse, then full rate on both sides.
    for (int stage = 0; stage < 3; stage++) begin
      case (stage)
        0: begin
          send_idle_pct = 20;
          recv_idle_pct = 57;
        end
        1: begin
          send_idle_pct = 57;
          recv_idle_pct = 20;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      target = bytes_sent + 320;
      while (bytes_sent < target) random_tga();
    end
    in_valid <= 1'b0;

    // Drain: let the last acceptance reach the checker, wait out the
    // expected words, then wait on for stragglers to show up.
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/tgarow_pkg.sv
rtl/tgarow_engine.sv
rtl/tga_truecolor_row_parser.sv
tb/tga_row_checker.sv
tb/tga_truecolor_row_parser_tb.sv
